@@ design/dra_pkg.sv @@
// ----------------------------------------------------------------------------
// dra_pkg: shared types and constants of the distance rank assigner
// Sequencer states, the rank unit control group, register map and the
// fixed widths of the result fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dra_pkg;

  // result field width (agent_index, agent_rank)
  localparam int RES_W = 6;

  // configuration port
  localparam int                ADDR_W         = 3;
  localparam int                DATA_W         = 32;
  localparam logic [ADDR_W-1:0] REG_ORDER_MODE = 3'h0;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } dra_state_t;

  typedef struct packed {
    logic clear;
    logic en;
  } dra_cmp_ctrl_t;

endpackage

`default_nettype wire

@@ design/dra_rank_unit.sv @@
// ----------------------------------------------------------------------------
// dra_rank_unit: shared compare and rank accumulator
// Compares one stored distance against the distance under ranking per
// cycle while enabled and counts the entries that sort ahead of it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dra_rank_unit
  import dra_pkg::*;
#(
  parameter int DIST_W = 11,
  parameter int IDX_W  = 6
) (
  input  wire logic          clk,
  input  wire dra_cmp_ctrl_t ctrl,
  input  wire logic [DIST_W-1:0] dist_ref,
  input  wire logic [IDX_W-1:0]  idx_ref,
  input  wire logic [DIST_W-1:0] dist_cmp,
  input  wire logic [IDX_W-1:0]  idx_cmp,
  output logic      [IDX_W-1:0]  rank
);

  logic ahead;

  assign ahead = (dist_cmp < dist_ref) || ((dist_cmp == dist_ref) && (idx_cmp < idx_ref));

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      rank <= '0;
    end else if (ctrl.en && ahead) begin
      rank <= rank + IDX_W'(1);
    end
  end

endmodule

`default_nettype wire

@@ design/distance_rank_assigner.sv @@
// ----------------------------------------------------------------------------
// distance_rank_assigner: rank grid agents by Manhattan distance
// Loads one agent per beat, stores its distance, and after the final agent
// emits one rank beat per stored agent in agent order.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------
//  in      | in_valid / in_stall       | start_row start_col goal_row
//          |                           | goal_col final_agent
//  out     | out_valid / out_stall     | agent_index agent_rank
//          |                           | end_of_ranks overflowed
//  cfg     | psel penable pwrite pready| paddr pwdata prdata
//
//  Loading accepts one agent beat per cycle while in_stall is low.
//  For each agent the single compare unit walks all n stored distances, one
//  per cycle, through the scan read port of the distance memory, and then
//  emits its rank beat, which out_stall can hold.
//  in_stall is high from the final agent beat until the last rank beat leaves.
//  Synchronous reset clears the sequencer, agent count, overflow flag and
//  order_mode; stored distances are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module distance_rank_assigner
  import dra_pkg::*;
#(
  parameter int MAX_AGENTS = 64,
  parameter int COORD_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // agent load channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_BITS-1:0] start_row,
  input  wire logic [COORD_BITS-1:0] start_col,
  input  wire logic [COORD_BITS-1:0] goal_row,
  input  wire logic [COORD_BITS-1:0] goal_col,
  input  wire logic                  final_agent,
  // rank result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [RES_W-1:0]           agent_index,
  output logic [RES_W-1:0]           agent_rank,
  output logic                       end_of_ranks,
  output logic                       overflowed,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  localparam int IDX_W  = $clog2(MAX_AGENTS);
  localparam int CNT_W  = $clog2(MAX_AGENTS + 1);
  localparam int DIST_W = COORD_BITS + 1;

  dra_state_t state, state_next;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_after;
  logic              ovf;
  logic              mode;
  logic              mode_lat;
  logic              ovf_lat;
  logic [IDX_W-1:0]  last_idx;
  logic [IDX_W-1:0]  i_idx;
  logic [IDX_W-1:0]  j_idx;
  logic [IDX_W-1:0]  cmp_j;
  logic              cmp_vld;
  logic [DIST_W-1:0] rd_a;
  logic [DIST_W-1:0] rd_b;
  logic [DIST_W-1:0] dist_mem [MAX_AGENTS];

  logic [COORD_BITS-1:0] diff_row;
  logic [COORD_BITS-1:0] diff_col;
  logic [DIST_W-1:0]     dist_new;

  logic          in_acc;
  logic          out_acc;
  logic          full;
  logic          cfg_wr;
  logic          fetch_en;
  logic          scan_en;
  dra_cmp_ctrl_t cmp_ctrl;
  logic [IDX_W-1:0] rank;
  logic [IDX_W-1:0] rank_sel;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign full    = (count == CNT_W'(MAX_AGENTS));
  assign cfg_wr  = psel && penable && pwrite && pready;

  assign count_after = full ? count : count + CNT_W'(1);

  assign diff_row = (start_row > goal_row) ? start_row - goal_row : goal_row - start_row;
  assign diff_col = (start_col > goal_col) ? start_col - goal_col : goal_col - start_col;
  assign dist_new = DIST_W'(diff_row) + DIST_W'(diff_col);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_acc && final_agent) state_next = ST_FETCH;
      end
      ST_FETCH: state_next = ST_SCAN;
      ST_SCAN: begin
        if (j_idx == last_idx) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_acc) state_next = (i_idx == last_idx) ? ST_LOAD : ST_FETCH;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    fetch_en  = 1'b0;
    scan_en   = 1'b0;
    unique case (state)
      ST_LOAD:  in_stall  = 1'b0;
      ST_FETCH: fetch_en  = 1'b1;
      ST_SCAN:  scan_en   = 1'b1;
      ST_DRAIN: ;
      ST_EMIT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      ovf     <= 1'b0;
      mode    <= 1'b0;
      cmp_vld <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= scan_en;
      if (cfg_wr && (paddr == REG_ORDER_MODE)) begin
        mode <= pwdata[0];
      end
      if (in_acc) begin
        if (final_agent) begin
          count <= '0;
          ovf   <= 1'b0;
        end else begin
          count <= count_after;
          ovf   <= ovf | full;
        end
      end
    end
  end

  // set snapshot and walk counters
  always_ff @(posedge clk) begin
    if (in_acc && final_agent) begin
      last_idx <= IDX_W'(count_after - CNT_W'(1));
      ovf_lat  <= ovf | full;
      mode_lat <= mode;
      i_idx    <= '0;
    end
    if (fetch_en) begin
      j_idx <= '0;
    end
    if (scan_en) begin
      j_idx <= j_idx + IDX_W'(1);
      cmp_j <= j_idx;
    end
    if (out_acc) begin
      i_idx <= i_idx + IDX_W'(1);
    end
  end

  // distance memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (in_acc && !full) begin
      dist_mem[count[IDX_W-1:0]] <= dist_new;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_en) begin
      rd_a <= dist_mem[i_idx];
    end
    if (scan_en) begin
      rd_b <= dist_mem[j_idx];
    end
  end

  assign cmp_ctrl.clear = fetch_en;
  assign cmp_ctrl.en    = cmp_vld;

  dra_rank_unit #(
    .DIST_W (DIST_W),
    .IDX_W  (IDX_W)
  ) u_rank (
    .clk      (clk),
    .ctrl     (cmp_ctrl),
    .dist_ref (rd_a),
    .idx_ref  (i_idx),
    .dist_cmp (rd_b),
    .idx_cmp  (cmp_j),
    .rank     (rank)
  );

  assign rank_sel     = mode_lat ? last_idx - rank : rank;
  assign agent_index  = RES_W'(i_idx);
  assign agent_rank   = RES_W'(rank_sel);
  assign end_of_ranks = (i_idx == last_idx);
  assign overflowed   = ovf_lat;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_ORDER_MODE) ? DATA_W'(mode) : '0;

endmodule

`default_nettype wire

@@ tb/sv/distance_rank_assigner_checker.sv @@
// ----------------------------------------------------------------------------
// distance_rank_assigner_checker: rank beat predictor and scoreboard
// Watches the agent load, rank result and configuration channels. Keeps its
// own distance store, agent count, overflow flag and order mode, builds the
// rank beats that each final agent should release, and compares every
// accepted rank beat field by field against the oldest one still pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module distance_rank_assigner_checker
  import dra_pkg::*;
#(
  parameter int MAX_AGENTS = 64,
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [COORD_BITS-1:0] start_row,
  input  logic [COORD_BITS-1:0] start_col,
  input  logic [COORD_BITS-1:0] goal_row,
  input  logic [COORD_BITS-1:0] goal_col,
  input  logic                  final_agent,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [RES_W-1:0]      agent_index,
  input  logic [RES_W-1:0]      agent_rank,
  input  logic                  end_of_ranks,
  input  logic                  overflowed,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [RES_W-1:0] index;
    logic [RES_W-1:0] rank;
    logic             last;
    logic             ovf;
  } rank_beat_t;

  rank_beat_t            rank_queue[$];
  rank_beat_t            want;
  logic [COORD_BITS:0]   dist_mem[MAX_AGENTS];
  logic [COORD_BITS-1:0] d_row;
  logic [COORD_BITS-1:0] d_col;
  int                    stored;
  logic                  dropped;
  logic                  reversed;

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report(input string what, input int got, input int exp_val);
    $display("%0t ns: rank beat %s: got %0d, want %0d", $time, what, got, exp_val);
    errors++;
  endtask

  // rank every stored agent against all others, then close the set
  task automatic rank_set();
    int         n;
    int         r;
    rank_beat_t b;
    n = stored;
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int j = 0; j < n; j++) begin
        if (dist_mem[j] < dist_mem[i] || (dist_mem[j] == dist_mem[i] && j < i)) r++;
      end
      if (reversed) r = n - 1 - r;
      b.index = i[RES_W-1:0];
      b.rank  = r[RES_W-1:0];
      b.last  = (i + 1 == n);
      b.ovf   = dropped;
      rank_queue.push_back(b);
    end
    stored  = 0;
    dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stored   = 0;
      dropped  = 1'b0;
      reversed = 1'b0;
      rank_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_ORDER_MODE) begin
        reversed = pwdata[0];
      end
      if (in_valid && !in_stall) begin
        d_row = (start_row > goal_row) ? start_row - goal_row : goal_row - start_row;
        d_col = (start_col > goal_col) ? start_col - goal_col : goal_col - start_col;
        if (stored < MAX_AGENTS) begin
          dist_mem[stored] = {1'b0, d_row} + {1'b0, d_col};
          stored++;
        end else begin
          dropped = 1'b1;
        end
        if (final_agent) rank_set();
      end
      if (out_valid && !out_stall) begin
        if (rank_queue.size() == 0) begin
          report("with none pending, agent_index", agent_index, -1);
        end else begin
          want = rank_queue.pop_front();
          if (agent_index !== want.index) report("agent_index", agent_index, want.index);
          if (agent_rank !== want.rank) report("agent_rank", agent_rank, want.rank);
          if (end_of_ranks !== want.last) report("end_of_ranks", end_of_ranks, want.last);
          if (overflowed !== want.ovf) report("overflowed", overflowed, want.ovf);
        end
      end
    end
    pending = rank_queue.size();
  end

endmodule

@@ tb/sv/distance_rank_assigner_tb.sv @@
// ----------------------------------------------------------------------------
// distance_rank_assigner_tb: agent set stimulus and verdict
// Loads sets of agents through the valid/stall channel under both order
// modes: corner coordinates, ties, single agents, full and overflowing sets,
// then random sets with random gaps and result stalls. The checker beside
// the block predicts and compares the rank beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module distance_rank_assigner_tb;
  import dra_pkg::*;

  localparam int MAX_AGENTS = 64;
  localparam int COORD_BITS = 10;
  localparam int CYCLE_LIMIT = 500000;
  localparam int LOAD_TARGET = 460;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [COORD_BITS-1:0] start_row = '0;
  logic [COORD_BITS-1:0] start_col = '0;
  logic [COORD_BITS-1:0] goal_row = '0;
  logic [COORD_BITS-1:0] goal_col = '0;
  logic                  final_agent = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [RES_W-1:0]      agent_index;
  logic [RES_W-1:0]      agent_rank;
  logic                  end_of_ranks;
  logic                  overflowed;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  int errors;
  int pending;
  int cycles = 0;
  int sent = 0;
  bit quiet = 1'b0;
  int stall_left = 0;
  int calm_left = 0;
  int pick;

  always #5 clk = ~clk;

  distance_rank_assigner #(
    .MAX_AGENTS(MAX_AGENTS),
    .COORD_BITS(COORD_BITS)
  ) dut (.*);

  distance_rank_assigner_checker #(
    .MAX_AGENTS(MAX_AGENTS),
    .COORD_BITS(COORD_BITS)
  ) rank_chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("distance_rank_assigner: mismatch");
      $finish;
    end
  end

  // result stall in bursts, with calm stretches in between
  always @(negedge clk) begin
    if (quiet || rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        stall_left = $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        if (pick == 3) calm_left = $urandom_range(20, 120);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_agent(input logic [COORD_BITS-1:0] sr, input logic [COORD_BITS-1:0] sc,
                            input logic [COORD_BITS-1:0] gr, input logic [COORD_BITS-1:0] gc,
                            input logic fin, input bit gaps);
    if (gaps && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    start_row   <= sr;
    start_col   <= sc;
    goal_row    <= gr;
    goal_col    <= gc;
    final_agent <= fin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // hold until every rank beat is out and the block is back to loading
  task automatic settle();
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic corner_set();
    send_agent(10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b1);
    send_agent(10'd1023, 10'd1023, 10'd0, 10'd0, 1'b0, 1'b1);
    send_agent(10'd0, 10'd1023, 10'd1023, 10'd0, 1'b0, 1'b1);
    send_agent(10'd5, 10'd5, 10'd5, 10'd5, 1'b0, 1'b1);
    send_agent(10'd0, 10'd0, 10'd1023, 10'd1023, 1'b0, 1'b1);
    send_agent(10'd512, 10'd0, 10'd0, 10'd512, 1'b0, 1'b1);
    send_agent(10'd3, 10'd7, 10'd1, 10'd2, 1'b1, 1'b1);
    send_agent(10'h2aa, 10'h155, 10'h155, 10'h2aa, 1'b1, 1'b1);
  endtask

  task automatic send_random_set(input int size);
    bit tight;
    bit gaps;
    int lim;
    tight = ($urandom_range(0, 2) == 0);
    gaps  = ($urandom_range(0, 2) != 0);
    lim   = tight ? 3 : 1023;
    for (int k = 0; k < size; k++) begin
      send_agent(COORD_BITS'($urandom_range(0, lim)), COORD_BITS'($urandom_range(0, lim)),
                 COORD_BITS'($urandom_range(0, lim)), COORD_BITS'($urandom_range(0, lim)),
                 k == size - 1, gaps);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    write_reg(REG_ORDER_MODE, {31'($urandom()), 1'b0});
    corner_set();
    settle();
    write_reg(REG_ORDER_MODE, {31'($urandom()), 1'b1});
    corner_set();
    send_agent(10'd7, 10'd7, 10'd7, 10'd7, 1'b0, 1'b0);
    send_agent(10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0);
    send_agent(10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b0, 1'b0);
    send_agent(10'd100, 10'd200, 10'd100, 10'd200, 1'b1, 1'b0);
    settle();

    for (int s = 0; sent < LOAD_TARGET; s++) begin
      if (sent >= LOAD_TARGET - 80) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) begin
        settle();
        write_reg(REG_ORDER_MODE, {31'($urandom()), 1'($urandom_range(0, 1))});
      end
      case (s)
        3:       send_random_set(MAX_AGENTS);
        7:       send_random_set(MAX_AGENTS + 1);
        12:      send_random_set(MAX_AGENTS + 6);
        default: send_random_set(($urandom_range(0, 4) == 0) ? $urandom_range(9, 20)
                                                             : $urandom_range(1, 8));
      endcase
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (40) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("distance_rank_assigner: match");
    end else begin
      $display("distance_rank_assigner: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/dra_pkg.sv
design/dra_rank_unit.sv
design/distance_rank_assigner.sv
tb/sv/distance_rank_assigner_checker.sv
tb/sv/distance_rank_assigner_tb.sv
